@@ sv/refcounted_inode_cache_table_assert.svh @@
// ----------------------------------------------------------------------------
// Inode cache assertion macros
// Shared concurrent check forms for the inode cache table.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_INODE_CACHE_TABLE_ASSERT_SVH
`define REFCOUNTED_INODE_CACHE_TABLE_ASSERT_SVH

// Same-cycle implication.
`define INOCACHE_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("inode cache check failed");

// Next-cycle implication.
`define INOCACHE_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("inode cache check failed");

`endif

@@ sv/inocache_pkg.sv @@
// ----------------------------------------------------------------------------
// Inode cache package
// Shared types, codes and constants of the inode cache table.
// ----------------------------------------------------------------------------
package inocache_pkg;

  localparam int ENTRIES_DEF      = 64;
  localparam int INODE_BITS_DEF   = 24;
  localparam int INODES_PER_BLOCK = 8;
  localparam int OFF_W            = $clog2(INODES_PER_BLOCK);
  localparam int START_W          = 24;
  localparam int BLOCK_W          = 25;
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef enum logic {
    CMD_ACQUIRE = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NO_FREE  = 2'd1,
    STS_NOT_HELD = 2'd2,
    STS_OVERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e        command;
    logic [7:0]  device;
    logic [23:0] inode_number;
    logic [5:0]  release_slot;
    logic        modified;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         slot;
    logic               hit;
    logic               load_needed;
    logic               writeback_needed;
    logic [BLOCK_W-1:0] disk_block;
    logic [OFF_W-1:0]   block_offset;
    status_e            status;
  } out_item_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic scan;
    logic commit;
    cmd_e cmd;
    logic modified;
    logic any_hit;
  } cell_ctl_t;

  // Per-cell report back to the result logic.
  typedef struct packed {
    logic       pick_hit;
    logic       pick_free;
    logic       addressed;
    logic       dirty;
    logic [7:0] count;
  } cell_stat_t;

endpackage

@@ sv/inocache_cell.sv @@
// ----------------------------------------------------------------------------
// Inode cache cell
// One table entry: tag compare, free test, priority link and count update.
// ----------------------------------------------------------------------------
module inocache_cell #(
  parameter int INDEX      = 0,
  parameter int INODE_BITS = inocache_pkg::INODE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  inocache_pkg::cell_ctl_t ctl,
  input  logic [7:0]              device,
  input  logic [INODE_BITS-1:0]   inode,
  input  logic [5:0]              release_slot,
  input  logic                    hit_seen_in,
  input  logic                    free_seen_in,
  output logic                    hit_seen_out,
  output logic                    free_seen_out,
  output inocache_pkg::cell_stat_t stat,
  output logic [INODE_BITS-1:0]   entry_ino
);

  logic [7:0]            entry_device;
  logic [INODE_BITS-1:0] entry_inode;
  logic [7:0]            refcount;
  logic                  dirty;
  logic                  match_q;
  logic                  free_q;
  logic                  addr_q;
  logic                  pick_hit;
  logic                  pick_free;

  // Priority links: a cell wins only if no lower cell already claimed.
  assign pick_hit      = match_q && !hit_seen_in;
  assign pick_free     = free_q && !free_seen_in;
  assign hit_seen_out  = hit_seen_in || match_q;
  assign free_seen_out = free_seen_in || free_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_device <= '0;
      entry_inode  <= '0;
      refcount     <= '0;
      dirty        <= 1'b0;
      match_q      <= 1'b0;
      free_q       <= 1'b0;
      addr_q       <= 1'b0;
    end else begin
      if (ctl.scan) begin
        match_q <= (entry_inode != '0) && (entry_device == device) && (entry_inode == inode);
        free_q  <= (refcount == '0);
        addr_q  <= (32'(release_slot) == 32'(INDEX));
      end
      if (ctl.commit) begin
        if (ctl.cmd == inocache_pkg::CMD_ACQUIRE) begin
          if (pick_hit) begin
            if (refcount != inocache_pkg::COUNT_MAX) begin
              refcount <= refcount + 8'd1;
            end
          end else if (pick_free && !ctl.any_hit) begin
            refcount     <= 8'd1;
            entry_device <= device;
            entry_inode  <= inode;
            dirty        <= 1'b0;
          end
        end else if (addr_q && (refcount != '0)) begin
          refcount <= refcount - 8'd1;
          // Drop the mark once the last reference goes and writeback is issued.
          if ((refcount == 8'd1) && (dirty || ctl.modified)) begin
            dirty <= 1'b0;
          end else if (ctl.modified) begin
            dirty <= 1'b1;
          end
        end
      end
    end
  end

  assign stat.pick_hit  = pick_hit;
  assign stat.pick_free = pick_free;
  assign stat.addressed = addr_q;
  assign stat.dirty     = dirty;
  assign stat.count     = refcount;
  assign entry_ino      = entry_inode;

endmodule

@@ sv/refcounted_inode_cache_table.sv @@
// ----------------------------------------------------------------------------
// Reference-counted inode cache table
// A row of entry cells with a priority chain, plus a two-step sequencer.
// ----------------------------------------------------------------------------
// Each accepted beat passes through a scan cycle, in which every cell
// compares its stored (device, inode) and tests for a zero count in parallel
// and registers the flags, and an update cycle, in which the hit and free
// flags ripple through the cell chain to pick the lowest match and the lowest
// free entry, the chosen cell updates, and the result beat is loaded into the
// output register. The block takes the next beat in the same cycle that the
// update lands, so a new request can follow each commit directly as
// long as the consumer keeps up; a full output register holds the update
// cycle until the waiting beat is taken. An acquire that hits bumps the count
// (or reports overflow at 255), a miss claims the lowest free slot and asks
// for a load from block (ino-1)/8 + inode_table_start at offset (ino-1)%8, and
// a release that drops a dirty entry to zero asks for a writeback there.
// Reset clears every entry at once; no sweep is needed. The table-start
// register is written through the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
`include "refcounted_inode_cache_table_assert.svh"

module refcounted_inode_cache_table #(
  parameter int ENTRIES    = inocache_pkg::ENTRIES_DEF,
  parameter int INODE_BITS = inocache_pkg::INODE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  inocache_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output inocache_pkg::out_item_t out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [inocache_pkg::START_W-1:0] cfg_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SUM_W = 34;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t                               state;
  state_t                               state_next;
  inocache_pkg::in_item_t               req;
  logic [inocache_pkg::START_W-1:0]     table_start;
  inocache_pkg::out_item_t              res;
  inocache_pkg::cell_ctl_t              ctl;
  logic                                 commit;
  logic                                 accept;

  logic                                 hit_chain  [ENTRIES+1];
  logic                                 free_chain [ENTRIES+1];
  inocache_pkg::cell_stat_t             cell_stat  [ENTRIES];
  logic [INODE_BITS-1:0]                cell_ino   [ENTRIES];

  logic [ENTRIES-1:0]                   pick_hit_vec;
  logic [ENTRIES-1:0]                   pick_free_vec;
  logic [IDX_W-1:0]                     hit_idx;
  logic [IDX_W-1:0]                     free_idx;
  logic [7:0]                           hit_cnt;
  logic [7:0]                           rel_cnt;
  logic                                 rel_dirty;
  logic                                 addressed_any;
  logic [INODE_BITS-1:0]                rel_ino;
  logic                                 any_hit;
  logic                                 any_free;
  logic                                 rel_held;
  logic                                 rel_wb;

  logic [INODE_BITS-1:0]                req_ino;
  logic [INODE_BITS-1:0]                loc_ino;
  logic [INODE_BITS-1:0]                loc_idx;
  logic [SUM_W-1:0]                     blk_sum;

  // --------------------------------------------------------------------------
  // Handshake and sequencing
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign commit    = (state == ST_UPDATE) && (!out_valid || out_ready);
  assign in_ready  = (state == ST_IDLE) || commit;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (commit) state_next = accept ? ST_SCAN : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      table_start <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) table_start <= cfg_data;
      // Hold the result until taken; a commit refills the register.
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request and result registers carry payload only.
  always_ff @(posedge clk) begin
    if (accept) req <= in_data;
    if (commit) out_data <= res;
  end

  // --------------------------------------------------------------------------
  // Cell row
  // --------------------------------------------------------------------------
  assign req_ino = INODE_BITS'(req.inode_number);

  assign ctl.scan     = (state == ST_SCAN);
  assign ctl.commit   = commit;
  assign ctl.cmd      = req.command;
  assign ctl.modified = req.modified;
  assign ctl.any_hit  = hit_chain[ENTRIES];

  assign hit_chain[0]  = 1'b0;
  assign free_chain[0] = 1'b0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    inocache_cell #(
      .INDEX      (g),
      .INODE_BITS (INODE_BITS)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctl           (ctl),
      .device        (req.device),
      .inode         (req_ino),
      .release_slot  (req.release_slot),
      .hit_seen_in   (hit_chain[g]),
      .free_seen_in  (free_chain[g]),
      .hit_seen_out  (hit_chain[g+1]),
      .free_seen_out (free_chain[g+1]),
      .stat          (cell_stat[g]),
      .entry_ino     (cell_ino[g])
    );
  end

  // Gather the one-hot picks into indexes and the chosen cell's state.
  always_comb begin
    pick_hit_vec  = '0;
    pick_free_vec = '0;
    hit_idx       = '0;
    free_idx      = '0;
    hit_cnt       = '0;
    rel_cnt       = '0;
    rel_dirty     = 1'b0;
    addressed_any = 1'b0;
    rel_ino       = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      pick_hit_vec[i]  = cell_stat[i].pick_hit;
      pick_free_vec[i] = cell_stat[i].pick_free;
      if (cell_stat[i].pick_hit) begin
        hit_idx = hit_idx | IDX_W'(i);
        hit_cnt = hit_cnt | cell_stat[i].count;
      end
      if (cell_stat[i].pick_free) begin
        free_idx = free_idx | IDX_W'(i);
      end
      if (cell_stat[i].addressed) begin
        addressed_any = 1'b1;
        rel_cnt       = rel_cnt | cell_stat[i].count;
        rel_dirty     = rel_dirty | cell_stat[i].dirty;
        rel_ino       = rel_ino | cell_ino[i];
      end
    end
  end

  assign any_hit  = hit_chain[ENTRIES];
  assign any_free = free_chain[ENTRIES];
  assign rel_held = addressed_any && (rel_cnt != '0);
  assign rel_wb   = rel_held && (rel_cnt == 8'd1) && (rel_dirty || req.modified);

  // --------------------------------------------------------------------------
  // Disk location: inode n sits at entry (n-1) of the table, eight per block.
  // --------------------------------------------------------------------------
  assign loc_ino = (req.command == inocache_pkg::CMD_ACQUIRE) ? req_ino : rel_ino;
  assign loc_idx = loc_ino - INODE_BITS'(1);
  assign blk_sum = SUM_W'(loc_idx >> inocache_pkg::OFF_W) + SUM_W'(table_start);

  always_comb begin
    res        = '0;
    res.status = inocache_pkg::STS_OK;
    if (req.command == inocache_pkg::CMD_ACQUIRE) begin
      if (any_hit) begin
        res.slot = 6'(hit_idx);
        res.hit  = 1'b1;
        if (hit_cnt == inocache_pkg::COUNT_MAX) res.status = inocache_pkg::STS_OVERFLOW;
      end else if (any_free) begin
        res.slot         = 6'(free_idx);
        res.load_needed  = 1'b1;
        res.disk_block   = blk_sum[inocache_pkg::BLOCK_W-1:0];
        res.block_offset = loc_idx[inocache_pkg::OFF_W-1:0];
      end else begin
        res.status = inocache_pkg::STS_NO_FREE;
      end
    end else begin
      res.slot = req.release_slot;
      if (!rel_held) begin
        res.status = inocache_pkg::STS_NOT_HELD;
      end else if (rel_wb) begin
        res.writeback_needed = 1'b1;
        res.disk_block       = blk_sum[inocache_pkg::BLOCK_W-1:0];
        res.block_offset     = loc_idx[inocache_pkg::OFF_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `INOCACHE_ASSERT_IMP(a_hit_pick_onehot, clk, rst, state == ST_UPDATE, $onehot0(pick_hit_vec))
  `INOCACHE_ASSERT_IMP(a_free_pick_onehot, clk, rst, state == ST_UPDATE, $onehot0(pick_free_vec))
  `INOCACHE_ASSERT_NEXT(a_commit_fills_out, clk, rst, commit, out_valid)
  `INOCACHE_ASSERT_NEXT(a_accept_starts_scan, clk, rst, accept, state == ST_SCAN)
  `INOCACHE_ASSERT_NEXT(a_scan_then_update, clk, rst, state == ST_SCAN, state == ST_UPDATE)

endmodule

@@ tb/refcounted_inode_cache_table_tb.sv @@
// ----------------------------------------------------------------------------
// Inode cache table testbench
// Drives acquire and release beats into the reference-counted inode cache and
// checks every result beat against a shadow copy of the table kept here. The
// run opens with a directed sequence (first claim, hit, revive, inode zero,
// writeback, release of an unheld slot), then random traffic in phases under
// several table-start settings: mixed traffic over a small key pool, a fill
// that runs the table out of free entries, and a saturation run that drives
// one entry's count into overflow. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module refcounted_inode_cache_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS   = inocache_pkg::ENTRIES_DEF;
  localparam int POOL     = 12;
  localparam int SAT_RUN  = 258;

  // --------------------------------------------------------------------------
  // Shadow of the table: predicts each result beat and checks what comes out.
  // --------------------------------------------------------------------------
  class inode_table_scoreboard;
    logic [7:0]                       shadow_dev   [NSLOTS];
    logic [23:0]                      shadow_ino   [NSLOTS];
    logic [7:0]                       shadow_refs  [NSLOTS];
    logic                             shadow_dirty [NSLOTS];
    logic [inocache_pkg::START_W-1:0] table_start;
    inocache_pkg::out_item_t          expected_replies [$];
    int                               mismatch_count;

    function new();
      for (int i = 0; i < NSLOTS; i++) begin
        shadow_dev[i]   = '0;
        shadow_ino[i]   = '0;
        shadow_refs[i]  = '0;
        shadow_dirty[i] = 1'b0;
      end
      table_start    = '0;
      mismatch_count = 0;
    endfunction

    // Home of an inode on disk: block (ino-1)/8 + table start, offset (ino-1)%8.
    // Inode zero wraps to the top of the inode space.
    function void inode_home(input logic [23:0] ino,
                             output logic [inocache_pkg::BLOCK_W-1:0] blk,
                             output logic [inocache_pkg::OFF_W-1:0] off);
      logic [23:0] idx;
      idx = ino - 24'd1;
      blk = inocache_pkg::BLOCK_W'(idx[23:3]) + inocache_pkg::BLOCK_W'(table_start);
      off = idx[2:0];
    endfunction

    function inocache_pkg::out_item_t predict_reply(inocache_pkg::in_item_t it);
      inocache_pkg::out_item_t r;
      int                      found;
      int                      free_slot;
      r        = '0;
      r.status = inocache_pkg::STS_OK;
      if (it.command == inocache_pkg::CMD_ACQUIRE) begin
        found     = -1;
        free_slot = -1;
        for (int i = 0; i < NSLOTS; i++) begin
          if (found < 0 && shadow_ino[i] != 0 && shadow_dev[i] == it.device &&
              shadow_ino[i] == it.inode_number)
            found = i;
          if (free_slot < 0 && shadow_refs[i] == 0)
            free_slot = i;
        end
        if (found >= 0) begin
          r.slot = 6'(found);
          r.hit  = 1'b1;
          if (shadow_refs[found] == inocache_pkg::COUNT_MAX)
            r.status = inocache_pkg::STS_OVERFLOW;
          else
            shadow_refs[found]++;
        end else if (free_slot >= 0) begin
          r.slot                  = 6'(free_slot);
          r.load_needed           = 1'b1;
          shadow_refs[free_slot]  = 8'd1;
          shadow_dev[free_slot]   = it.device;
          shadow_ino[free_slot]   = it.inode_number;
          shadow_dirty[free_slot] = 1'b0;
          inode_home(it.inode_number, r.disk_block, r.block_offset);
        end else begin
          r.status = inocache_pkg::STS_NO_FREE;
        end
      end else begin
        r.slot = it.release_slot;
        if (int'(it.release_slot) >= NSLOTS || shadow_refs[it.release_slot] == 0) begin
          r.status = inocache_pkg::STS_NOT_HELD;
        end else begin
          if (it.modified)
            shadow_dirty[it.release_slot] = 1'b1;
          shadow_refs[it.release_slot]--;
          if (shadow_refs[it.release_slot] == 0 && shadow_dirty[it.release_slot]) begin
            r.writeback_needed = 1'b1;
            inode_home(shadow_ino[it.release_slot], r.disk_block, r.block_offset);
            shadow_dirty[it.release_slot] = 1'b0;
          end
        end
      end
      return r;
    endfunction

    function void note_request(inocache_pkg::in_item_t it);
      expected_replies.push_back(predict_reply(it));
    endfunction

    task report_mismatch(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatch_count++;
    endtask

    task field_check(string name, logic [31:0] got_v, logic [31:0] exp_v);
      if (got_v !== exp_v)
        report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got_v, exp_v));
    endtask

    task check_response(inocache_pkg::out_item_t got);
      inocache_pkg::out_item_t exp;
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected: %p", got));
        return;
      end
      exp = expected_replies.pop_front();
      field_check("slot", 32'(got.slot), 32'(exp.slot));
      field_check("hit", 32'(got.hit), 32'(exp.hit));
      field_check("load_needed", 32'(got.load_needed), 32'(exp.load_needed));
      field_check("writeback_needed", 32'(got.writeback_needed),
                  32'(exp.writeback_needed));
      field_check("disk_block", 32'(got.disk_block), 32'(exp.disk_block));
      field_check("block_offset", 32'(got.block_offset), 32'(exp.block_offset));
      field_check("status", 32'(got.status), 32'(exp.status));
    endtask

    function int pending();
      return expected_replies.size();
    endfunction

    function int free_count();
      int n;
      n = 0;
      for (int i = 0; i < NSLOTS; i++)
        if (shadow_refs[i] == 0) n++;
      return n;
    endfunction

    // Any held slot, scanning from a random start; -1 if none is held.
    function int held_slot();
      int start;
      start = $urandom_range(NSLOTS - 1, 0);
      for (int i = 0; i < NSLOTS; i++)
        if (shadow_refs[(start + i) % NSLOTS] != 0) return (start + i) % NSLOTS;
      return -1;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs, all known from time zero.
  // --------------------------------------------------------------------------
  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             in_valid  = 1'b0;
  logic                             in_ready;
  inocache_pkg::in_item_t           in_data   = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  inocache_pkg::out_item_t          out_data;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [inocache_pkg::START_W-1:0] cfg_data  = '0;

  inode_table_scoreboard cache_model = new();

  logic [7:0]  pool_dev [POOL];
  logic [23:0] pool_ino [POOL];
  int          burst_left = 0;
  int          rx_mode    = 0;
  int          rx_left    = 0;

  always #5 clk = ~clk;

  refcounted_inode_cache_table DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Receiver: check each accepted result beat, then pick the next ready value.
  // Modes: always ready, coin flip, mostly stalled, and short hard stalls.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bit [31:0] coin;
    coin = $urandom;
    if (!rst && out_valid && out_ready)
      cache_model.check_response(out_data);
    if (rx_left == 0) begin
      rx_mode = $urandom_range(3, 0);
      rx_left = (rx_mode == 3) ? $urandom_range(12, 1) : $urandom_range(60, 10);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= coin[0];
      2: out_ready <= (coin[1:0] == 2'b00);
      default: out_ready <= 1'b0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sender. Every field is filled with noise first so unused fields toggle too.
  // --------------------------------------------------------------------------
  function automatic inocache_pkg::in_item_t noise_item();
    inocache_pkg::in_item_t it;
    bit [31:0]              r0;
    bit [31:0]              r1;
    r0 = $urandom;
    r1 = $urandom;
    it.command      = r0[31] ? inocache_pkg::CMD_RELEASE : inocache_pkg::CMD_ACQUIRE;
    it.device       = r0[7:0];
    it.inode_number = r1[23:0];
    it.release_slot = r0[13:8];
    it.modified     = r0[14];
    return it;
  endfunction

  function automatic inocache_pkg::in_item_t make_item(inocache_pkg::cmd_e cmd,
                                                       logic [7:0] dev, logic [23:0] ino,
                                                       logic [5:0] rslot, logic mod);
    inocache_pkg::in_item_t it;
    it.command      = cmd;
    it.device       = dev;
    it.inode_number = ino;
    it.release_slot = rslot;
    it.modified     = mod;
    return it;
  endfunction

  // Acquire either a pooled key (so hits happen) or a fresh random one.
  function automatic inocache_pkg::in_item_t acquire_item(bit from_pool);
    inocache_pkg::in_item_t it;
    int                     k;
    it         = noise_item();
    it.command = inocache_pkg::CMD_ACQUIRE;
    if (from_pool) begin
      k               = $urandom_range(POOL - 1, 0);
      it.device       = pool_dev[k];
      it.inode_number = pool_ino[k];
    end
    return it;
  endfunction

  // Release a slot that is held right now; fall back to a noise slot otherwise.
  function automatic inocache_pkg::in_item_t release_item();
    inocache_pkg::in_item_t it;
    int                     s;
    it         = noise_item();
    it.command = inocache_pkg::CMD_RELEASE;
    s          = cache_model.held_slot();
    if (s >= 0) it.release_slot = 6'(s);
    return it;
  endfunction

  // Send one beat: open a new burst after a random gap when the last one ran out,
  // hold valid and payload until the beat is taken, then note it.
  task automatic push(inocache_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(16, 1);
      gap        = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    cache_model.note_request(it);
  endtask

  // Drop valid and hold off until every expected result beat has come back.
  task automatic wait_for_replies();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (cache_model.pending() != 0) @(posedge clk);
  endtask

  // Write the table start; only called with the block idle.
  task automatic write_table_start(logic [inocache_pkg::START_W-1:0] v);
    wait_for_replies();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cache_model.table_start = v;
  endtask

  // --------------------------------------------------------------------------
  // Directed opening: first claim, hit, extreme device and inode, inode zero
  // claiming fresh entries, dirty release with writeback, unheld releases,
  // revival of a zero-count entry, same inode on another device.
  // --------------------------------------------------------------------------
  task automatic run_directed();
    push(make_item(inocache_pkg::CMD_ACQUIRE, 8'd0,  24'd1,      6'd0,  1'b0));
    push(make_item(inocache_pkg::CMD_ACQUIRE, 8'd0,  24'd1,      6'd0,  1'b0));
    push(make_item(inocache_pkg::CMD_ACQUIRE, 8'hFF, 24'hFFFFFF, 6'd0,  1'b0));
    push(make_item(inocache_pkg::CMD_ACQUIRE, 8'd0,  24'd0,      6'd0,  1'b0));
    push(make_item(inocache_pkg::CMD_ACQUIRE, 8'd0,  24'd0,      6'd0,  1'b0));
    push(make_item(inocache_pkg::CMD_RELEASE, 8'd0,  24'd0,      6'd2,  1'b1));
    push(make_item(inocache_pkg::CMD_RELEASE, 8'd0,  24'd0,      6'd2,  1'b1));
    push(make_item(inocache_pkg::CMD_RELEASE, 8'hFF, 24'hFFFFFF, 6'd63, 1'b1));
    push(make_item(inocache_pkg::CMD_ACQUIRE, 8'hFF, 24'hFFFFFF, 6'd63, 1'b1));
    push(make_item(inocache_pkg::CMD_RELEASE, 8'd0,  24'd0,      6'd1,  1'b1));
    push(make_item(inocache_pkg::CMD_RELEASE, 8'd0,  24'd0,      6'd1,  1'b0));
    push(make_item(inocache_pkg::CMD_ACQUIRE, 8'hFF, 24'hFFFFFF, 6'd0,  1'b0));
    push(make_item(inocache_pkg::CMD_RELEASE, 8'd0,  24'd0,      6'd0,  1'b0));
    push(make_item(inocache_pkg::CMD_ACQUIRE, 8'd1,  24'd1,      6'd0,  1'b0));
    push(make_item(inocache_pkg::CMD_ACQUIRE, 8'd0,  24'd9,      6'd0,  1'b0));
    push(make_item(inocache_pkg::CMD_ACQUIRE, 8'd0,  24'd8,      6'd0,  1'b0));
    push(make_item(inocache_pkg::CMD_RELEASE, 8'd0,  24'd0,      6'd3,  1'b0));
    push(make_item(inocache_pkg::CMD_RELEASE, 8'hFF, 24'hFFFFFF, 6'd3,  1'b1));
  endtask

  // Mixed traffic: acq_pct percent acquires (mostly pooled keys), the rest
  // releases of held slots with a share of noise releases. Now and then
  // pause until the block has drained.
  task automatic run_mix(int n, int acq_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99, 0);
      if (r < acq_pct)
        push(acquire_item($urandom_range(9, 0) < 7));
      else if (r < 92)
        push(release_item());
      else
        push(make_item(inocache_pkg::CMD_RELEASE, 8'($urandom), 24'($urandom),
                       6'($urandom), 1'($urandom)));
      if ($urandom_range(99, 0) == 0) wait_for_replies();
    end
  endtask

  // Claim fresh keys until no entry is free, then knock on the full table.
  task automatic run_fill();
    for (int i = 0; i < 200 && cache_model.free_count() > 0; i++)
      push(acquire_item(1'b0));
    repeat (3) push(acquire_item(1'b0));
    push(acquire_item(1'b1));
  endtask

  // Hammer one pooled key until its count saturates and overflows.
  task automatic run_saturate();
    inocache_pkg::in_item_t it;
    while (cache_model.free_count() == 0) push(release_item());
    it = acquire_item(1'b1);
    for (int i = 0; i < SAT_RUN; i++) begin
      it.release_slot = 6'($urandom);
      it.modified     = 1'($urandom);
      push(it);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    for (int k = 0; k < POOL; k++) begin
      pool_dev[k] = (k < 6) ? 8'(k % 3) : 8'($urandom);
      case (k)
        0: pool_ino[k] = 24'd1;
        1: pool_ino[k] = 24'd8;
        2: pool_ino[k] = 24'd9;
        3: pool_ino[k] = 24'hFFFFFF;
        default: pool_ino[k] = (k < 8) ? 24'($urandom_range(64, 1)) : 24'($urandom);
      endcase
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    write_table_start(24'hFFFFFF);
    run_mix(120, 50);
    run_fill();
    run_mix(80, 25);

    write_table_start(24'd0);
    run_saturate();

    write_table_start(24'($urandom));
    run_mix(120, 55);

    write_table_start(24'd1);
    run_mix(80, 60);

    // Drain, then keep the clock running so any stray beat can still show up.
    wait_for_replies();
    repeat (8) @(posedge clk);
    if (cache_model.mismatch_count == 0)
      $display("refcounted_inode_cache_table_tb: done, clean");
    else
      $display("refcounted_inode_cache_table_tb: done, errors");
    $finish;
  end

  // Watchdog: well past the slowest legal run.
  initial begin
    #2_000_000;
    $display("refcounted_inode_cache_table_tb: done, errors");
    $finish;
  end

endmodule
